[rtl/coalescing_interval_set_assert.svh]
// ----------------------------------------------------------------------------
// coalescing_interval_set_assert.svh
// Assertion macros for the interval set block.
// ----------------------------------------------------------------------------
`ifndef COALESCING_INTERVAL_SET_ASSERT_SVH
`define COALESCING_INTERVAL_SET_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CIS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("interval set check failed");

// Next-cycle implication, checked out of reset.
`define CIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("interval set check failed");

`endif

[rtl/cis_pkg.sv]
// ----------------------------------------------------------------------------
// cis_pkg
// Shared types and codes for the coalescing interval set.
// ----------------------------------------------------------------------------
package cis_pkg;

    localparam int SEQ_W = 31;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_ORDER = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             hole;
        logic [SEQ_W-1:0] first;
        logic [SEQ_W-1:0] last;
    } cis_range_t;

    typedef struct packed {
        logic eval;
        logic insert;
        logic merge;
        logic shift;
    } cis_ctrl_t;

endpackage

[rtl/cis_cell.sv]
// ----------------------------------------------------------------------------
// cis_cell
// One slot of the sorted range row: classifies, inserts, merges and shifts.
// ----------------------------------------------------------------------------
module cis_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cis_pkg::cis_ctrl_t        ctrl,
    input  logic [cis_pkg::SEQ_W-1:0] probe_first,
    input  logic [cis_pkg::SEQ_W-1:0] probe_last,
    input  logic [cis_pkg::SEQ_W-1:0] union_first,
    input  logic [cis_pkg::SEQ_W-1:0] union_last,
    input  logic [IW-1:0]             holepos,
    input  cis_pkg::cis_range_t       left_q,
    input  cis_pkg::cis_range_t       right_q,
    input  logic                      left_below,
    input  logic                      left_ovl,
    input  logic                      right_ovl,
    output cis_pkg::cis_range_t       cell_q,
    output logic                      below,
    output logic                      ovl,
    output logic                      first_ovl,
    output logic                      last_ovl,
    output logic                      hit
);

    cis_pkg::cis_range_t range_reg, range_next;
    logic below_reg, below_next;
    logic ovl_reg, ovl_next;
    logic hit_reg, hit_next;
    logic [cis_pkg::SEQ_W:0] end_inc;
    logic [cis_pkg::SEQ_W:0] probe_inc;

    assign end_inc   = {1'b0, range_reg.last} + 1'b1;
    assign probe_inc = {1'b0, probe_last} + 1'b1;

    always_comb begin
        range_next = range_reg;
        below_next = below_reg;
        ovl_next   = ovl_reg;
        hit_next   = hit_reg;
        if (ctrl.eval) begin
            below_next = range_reg.valid && (end_inc < {1'b0, probe_first});
            ovl_next   = range_reg.valid && !(end_inc < {1'b0, probe_first})
                         && ({1'b0, range_reg.first} <= probe_inc);
            hit_next   = range_reg.valid && (probe_first >= range_reg.first)
                         && (probe_first <= range_reg.last);
        end
        if (ctrl.insert && !below_reg) begin
            if (left_below) begin
                range_next = '{valid: 1'b1, hole: 1'b0, first: probe_first, last: probe_last};
            end else begin
                range_next = left_q;
            end
        end
        if (ctrl.merge && ovl_reg) begin
            if (!left_ovl) begin
                range_next = '{valid: 1'b1, hole: 1'b0, first: union_first, last: union_last};
            end else begin
                range_next.valid = 1'b0;
                range_next.hole  = 1'b1;
            end
        end
        if (ctrl.shift && (IW'(IDX) >= holepos)) begin
            range_next = right_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg.valid <= 1'b0;
            range_reg.hole  <= 1'b0;
            below_reg       <= 1'b0;
            ovl_reg         <= 1'b0;
            hit_reg         <= 1'b0;
        end else begin
            range_reg.valid <= range_next.valid;
            range_reg.hole  <= range_next.hole;
            below_reg       <= below_next;
            ovl_reg         <= ovl_next;
            hit_reg         <= hit_next;
        end
        range_reg.first <= range_next.first;
        range_reg.last  <= range_next.last;
    end

    assign cell_q    = range_reg;
    assign below     = below_reg;
    assign ovl       = ovl_reg;
    assign first_ovl = ovl_reg && !left_ovl;
    assign last_ovl  = ovl_reg && !right_ovl;
    assign hit       = hit_reg;

endmodule

[rtl/coalescing_interval_set.sv]
// ----------------------------------------------------------------------------
// coalescing_interval_set
// Sorted table of closed sequence ranges with coalescing add and query.
// ----------------------------------------------------------------------------
// Input items arrive on s_*: s_tuser selects add (0) or query (1); s_tdata
// holds first_seq and last_seq. Each item gives one result item on m_*:
// found, status and the number of ranges held after the item.
// The table is a row of cells, one range each, kept sorted by start.
// A query, or an add that merges at most one stored range, goes from
// acceptance to result through classify, apply and load output.
// An add that merges k > 1 stored ranges adds a shift step after apply:
// the row closes the gap by one cell per cycle until no hole is left.
// One item is in work at a time; the next one is taken once the result has
// moved to the output register, so a waiting result does not hold the input.
// If m_tready stays low the result holds and the following item stops after
// its apply step until the output register is free.
// Reset (aresetn low, synchronous) empties the table and drops any result.
// ----------------------------------------------------------------------------
module coalescing_interval_set #(
    parameter int MAX_RANGES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // first_seq[30:0], last_seq[61:31], zero pad
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // found[0], status[2:1], ranges_held[7:3]
);

    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EVAL  = 5'b00010,
        ST_APPLY = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic cmd_reg, cmd_next;
    logic [cis_pkg::SEQ_W-1:0] first_reg, first_next;
    logic [cis_pkg::SEQ_W-1:0] last_reg, last_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] holepos_reg, holepos_next;
    logic found_reg, found_next;
    logic [1:0] status_reg, status_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;

    cis_pkg::cis_ctrl_t ctrl;
    cis_pkg::cis_range_t cell_q [MAX_RANGES];
    logic [MAX_RANGES-1:0] below_v, ovl_v, first_v, last_v, hit_v, hole_v;

    logic [cis_pkg::SEQ_W-1:0] sel_first, sel_last, union_first, union_last;
    logic [IW-1:0] lo_idx;
    logic any_ovl, multi_ovl, any_hole, any_hit, in_accept, out_free, add_ok;

    genvar g;
    generate
        for (g = 0; g < MAX_RANGES; g++) begin : g_cell
            cis_pkg::cis_range_t left_q, right_q;
            logic left_below, left_ovl, right_ovl;
            if (g == 0) begin : g_head
                assign left_q     = '0;
                assign left_below = 1'b1;
                assign left_ovl   = 1'b0;
            end else begin : g_mid
                assign left_q     = cell_q[g-1];
                assign left_below = below_v[g-1];
                assign left_ovl   = ovl_v[g-1];
            end
            if (g == MAX_RANGES - 1) begin : g_tail
                assign right_q   = '0;
                assign right_ovl = 1'b0;
            end else begin : g_body
                assign right_q   = cell_q[g+1];
                assign right_ovl = ovl_v[g+1];
            end
            cis_cell #(
                .IDX (g),
                .IW  (IW)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .probe_first (first_reg),
                .probe_last  (last_reg),
                .union_first (union_first),
                .union_last  (union_last),
                .holepos     (holepos_reg),
                .left_q      (left_q),
                .right_q     (right_q),
                .left_below  (left_below),
                .left_ovl    (left_ovl),
                .right_ovl   (right_ovl),
                .cell_q      (cell_q[g]),
                .below       (below_v[g]),
                .ovl         (ovl_v[g]),
                .first_ovl   (first_v[g]),
                .last_ovl    (last_v[g]),
                .hit         (hit_v[g])
            );
            assign hole_v[g] = cell_q[g].hole;
        end
    endgenerate

    always_comb begin
        sel_first = '0;
        sel_last  = '0;
        lo_idx    = '0;
        for (int i = 0; i < MAX_RANGES; i++) begin
            sel_first = sel_first | (first_v[i] ? cell_q[i].first : '0);
            sel_last  = sel_last  | (last_v[i]  ? cell_q[i].last  : '0);
            lo_idx    = lo_idx    | (first_v[i] ? IW'(i) : '0);
        end
    end

    assign union_first = (sel_first < first_reg) ? sel_first : first_reg;
    assign union_last  = (sel_last > last_reg)   ? sel_last  : last_reg;
    assign any_ovl   = |ovl_v;
    assign multi_ovl = |(ovl_v & ~first_v);
    assign any_hole  = |hole_v;
    assign any_hit   = |hit_v;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign add_ok    = (cmd_reg == cis_pkg::CMD_ADD) && !(first_reg > last_reg);

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        count_next    = count_reg;
        holepos_next  = holepos_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ctrl          = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (in_accept) begin
                    cmd_next   = s_tuser[0];
                    first_next = s_tdata[cis_pkg::SEQ_W-1:0];
                    last_next  = s_tdata[2*cis_pkg::SEQ_W-1:cis_pkg::SEQ_W];
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                ctrl.eval  = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                found_next  = 1'b0;
                status_next = cis_pkg::STAT_OK;
                state_next  = ST_DONE;
                if (cmd_reg == cis_pkg::CMD_QUERY) begin
                    found_next = any_hit;
                end else if (!add_ok) begin
                    status_next = cis_pkg::STAT_ORDER;
                end else if (!any_ovl) begin
                    if (count_reg == CW'(MAX_RANGES)) begin
                        status_next = cis_pkg::STAT_FULL;
                    end else begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end else begin
                    ctrl.merge   = 1'b1;
                    holepos_next = lo_idx + 1'b1;
                    if (multi_ovl) begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                if (any_hole) begin
                    ctrl.shift = 1'b1;
                    count_next = count_reg - 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'(count_reg), status_reg, found_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg     <= cmd_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        holepos_reg <= holepos_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`include "coalescing_interval_set_assert.svh"

    `CIS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CW'(MAX_RANGES))
    `CIS_ASSERT_IMPL(a_no_hole_done, state_reg == ST_DONE, !any_hole)
    `CIS_ASSERT_IMPL(a_full_count, (state_reg == ST_DONE) && (status_reg == cis_pkg::STAT_FULL),
                     count_reg == CW'(MAX_RANGES))
    `CIS_ASSERT_NEXT(a_accept_eval, in_accept, (state_reg == ST_EVAL) && !s_tready)

endmodule
